// ----- design/sra_pkg.sv -----
package sra_pkg;

  // ASCII codes used by the character mapping
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  // Base limits and reset base
  localparam logic [5:0] BASE_MIN   = 6'd2;
  localparam logic [5:0] BASE_MAX   = 6'd36;
  localparam logic [5:0] BASE_RESET = 6'd10;

  // Width of the converted value and of its bit counter
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned BITCNT_W = $clog2(VALUE_W);

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture value, magnitude and base
    logic div_step;    // one restoring division bit
    logic emit_sign;   // present the minus sign
    logic rd;          // read the digit store at the read index
    logic emit_digit;  // present the digit just read
  } sra_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_bit;    // this division step finishes a digit
    logic more;        // another digit follows
    logic neg;         // value is negative
    logic idx_zero;    // read index points at the lowest digit
  } sra_status_t;

  // Digit value to lowercase ASCII, out-of-range digits map to '0'
  function automatic logic [7:0] digit_char(input logic [5:0] d);
    logic [7:0] c;
    if (d < 6'd10) begin
      c = CHAR_ZERO + {2'b00, d};
    end else if (d < BASE_MAX) begin
      c = CHAR_LOWER_A + {2'b00, d} - 8'd10;
    end else begin
      c = CHAR_ZERO;
    end
    return c;
  endfunction

endpackage

// ----- design/sra_ctrl.sv -----
module sra_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  sra_pkg::sra_status_t status_i,
  output sra_pkg::sra_cmd_t    cmd_o
);
  import sra_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SIGN = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.last_bit && !status_i.more) begin
          state_d = status_i.neg ? ST_SIGN : ST_RD;
        end
      end
      ST_SIGN: begin
        cmd_o.emit_sign = 1'b1;
        state_d         = ST_RD;
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit_digit = 1'b1;
        state_d          = status_i.idx_zero ? ST_IDLE : ST_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// ----- design/sra_datapath.sv -----
module sra_datapath #(
  parameter int unsigned MAX_DIGITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [31:0]          value_i,
  input  logic                 cfg_we_i,
  input  logic [5:0]           cfg_wdata_i,
  input  sra_pkg::sra_cmd_t    cmd_i,
  output sra_pkg::sra_status_t status_o,
  output logic [7:0]           character_o,
  output logic                 last_o,
  output logic                 strobe_o
);
  import sra_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_DIGITS);
  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);
  localparam logic [CntW-1:0] CntTop = CntW'(MAX_DIGITS - 1);

  logic [5:0]          radix_q;
  logic [5:0]          base_q;
  logic                neg_q;
  logic [VALUE_W-1:0]  mag_q;
  logic [5:0]          rem_q;
  logic [BITCNT_W-1:0] bit_q;
  logic [CntW-1:0]     count_q;
  logic [IdxW-1:0]     rd_idx_q;
  logic [5:0]          rdata_q;
  logic [5:0]          mem_q [MAX_DIGITS];
  logic [7:0]          char_q;
  logic                last_q;
  logic                strobe_q;

  logic [6:0]          trial;
  logic                qbit;
  logic [5:0]          rem_next;
  logic [VALUE_W-1:0]  mag_next;
  logic                last_bit;
  logic [5:0]          base_eff;
  logic [VALUE_W-1:0]  mag_load;

  // Base clamp and magnitude of the incoming value
  always_comb begin
    if (radix_q < BASE_MIN) begin
      base_eff = BASE_MIN;
    end else if (radix_q > BASE_MAX) begin
      base_eff = BASE_MAX;
    end else begin
      base_eff = radix_q;
    end
    mag_load = value_i[VALUE_W-1] ? (~value_i + 32'd1) : value_i;
  end

  // One restoring division step
  always_comb begin
    trial    = {rem_q, mag_q[VALUE_W-1]};
    qbit     = (trial >= {1'b0, base_q});
    rem_next = qbit ? 6'(trial - {1'b0, base_q}) : trial[5:0];
    mag_next = {mag_q[VALUE_W-2:0], qbit};
    last_bit = (bit_q == BITCNT_W'(VALUE_W - 1));
  end

  assign status_o.last_bit = last_bit;
  assign status_o.more     = (mag_next != '0) && (count_q != CntTop);
  assign status_o.neg      = neg_q;
  assign status_o.idx_zero = (rd_idx_q == '0);

  // Radix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= BASE_RESET;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  // Divider, digit count and read index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      bit_q    <= '0;
      rem_q    <= '0;
      rd_idx_q <= '0;
    end else if (cmd_i.load) begin
      count_q <= '0;
      bit_q   <= '0;
      rem_q   <= '0;
    end else if (cmd_i.div_step) begin
      bit_q <= bit_q + 1'b1;
      if (last_bit) begin
        rem_q    <= '0;
        count_q  <= count_q + 1'b1;
        rd_idx_q <= count_q[IdxW-1:0];
      end else begin
        rem_q <= rem_next;
      end
    end else if (cmd_i.emit_digit && (rd_idx_q != '0)) begin
      rd_idx_q <= rd_idx_q - 1'b1;
    end
  end

  // Request payload: magnitude, sign, base
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q  <= mag_load;
      neg_q  <= value_i[VALUE_W-1];
      base_q <= base_eff;
    end else if (cmd_i.div_step) begin
      mag_q <= mag_next;
    end
  end

  // Digit store
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step && last_bit) begin
      mem_q[count_q[IdxW-1:0]] <= rem_next;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[rd_idx_q];
    end
  end

  // Output strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit_sign | cmd_i.emit_digit;
    end
  end

  // Output character
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      char_q <= CHAR_MINUS;
      last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= digit_char(rdata_q);
      last_q <= (rd_idx_q == '0);
    end
  end

  assign character_o = char_q;
  assign last_o      = last_q;
  assign strobe_o    = strobe_q;

endmodule

// ----- design/signed_radix_to_ascii_core.sv -----
// Digits come from a bit-serial restoring divider; each character is then read from the
// digit store and emitted, preceded by a minus sign for a negative value.
// One value at a time: a new start is taken once busy is low.
// Characters appear for one cycle each with strobe_o; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) idles the block and sets the radix to 10.
module signed_radix_to_ascii_core #(
  parameter int unsigned MAX_DIGITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value_i,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  output logic [7:0]  character_o,
  output logic        last_o,
  output logic        strobe_o
);
  import sra_pkg::*;

  sra_cmd_t    cmd;
  sra_status_t status;

  sra_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  sra_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .character_o (character_o),
    .last_o      (last_o),
    .strobe_o    (strobe_o)
  );

endmodule
